// File: rtl/core/ttdp_pkg.sv
// ----------------------------------------------------------------------------
// ttdp_pkg: transposition table shared definitions
// Types, codes and reset constants used by the table datapath and control.
// ----------------------------------------------------------------------------
package ttdp_pkg;

  // default table size (power of two)
  localparam int unsigned TableEntriesDefault = 4096;

  // register reset values
  localparam logic [14:0] MateScoreReset = 15'd10000;
  localparam logic [14:0] WinThreshReset = 15'd9900;

  // operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_SAVE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // bound kinds (anything else counts as exact)
  localparam logic [1:0] BOUND_UPPER = 2'd0;
  localparam logic [1:0] BOUND_LOWER = 2'd1;

  // configuration register indexes
  localparam logic CFG_MATE_SCORE = 1'b0;
  localparam logic CFG_WIN_THRESH = 1'b1;

  // one table entry: full key plus payload
  typedef struct packed {
    logic [31:0] key;
    logic [1:0]  bound;
    logic [7:0]  depth;
    logic [15:0] score;
    logic [15:0] move;
  } ttdp_entry_t;

  localparam int unsigned EntryWidth = $bits(ttdp_entry_t);

  // latched request fields
  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] key;
    logic [7:0]  ply_dist;
    logic [7:0]  depth;
    logic [15:0] alpha;
    logic [15:0] beta;
    logic [1:0]  bound;
    logic [15:0] score;
    logic [15:0] move;
    logic        allow_null;
  } ttdp_req_t;

  // configuration values
  typedef struct packed {
    logic [14:0] mate_score;
    logic [14:0] win_thresh;
  } ttdp_cfg_t;

  // result fields
  typedef struct packed {
    logic [15:0] score;
    logic [15:0] move;
    logic        usable;
    logic        accepted;
    logic        cleared;
  } ttdp_result_t;

  // write-back request from the evaluation logic
  typedef struct packed {
    logic        we;
    ttdp_entry_t entry;
  } ttdp_wb_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_PROBE,
    ST_CLEAR
  } ttdp_state_e;

endpackage

// File: rtl/core/ttdp_mem.sv
// ----------------------------------------------------------------------------
// ttdp_mem: table storage
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ttdp_mem import ttdp_pkg::*; #(
  parameter int unsigned Entries = TableEntriesDefault,
  parameter int unsigned IdxW    = $clog2(Entries)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [IdxW-1:0]       waddr_i,
  input  logic [EntryWidth-1:0] wdata_i,
  input  logic                  re_i,
  input  logic [IdxW-1:0]       raddr_i,
  output logic [EntryWidth-1:0] rdata_o
);

  logic [EntryWidth-1:0] mem [Entries];
  logic [EntryWidth-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/ttdp_eval.sv
// ----------------------------------------------------------------------------
// ttdp_eval: probe evaluation
// Decides the load result and the save write-back from the entry just read.
// ----------------------------------------------------------------------------
module ttdp_eval import ttdp_pkg::*; (
  input  ttdp_req_t    req_i,
  input  ttdp_entry_t  entry_i,
  input  ttdp_cfg_t    cfg_i,
  output ttdp_result_t res_o,
  output ttdp_wb_t     wb_o
);

  logic signed [17:0] win, sval, adj, ply_dist, alpha, beta, sin, vsum, vsat;
  logic               hit, null_refused, is_mate, depth_ok, usable;
  logic               in_hi, in_lo;

  assign win      = $signed({3'b000, cfg_i.win_thresh});
  assign ply_dist = $signed({10'd0, req_i.ply_dist});
  assign sval     = 18'($signed(entry_i.score));
  assign alpha    = 18'($signed(req_i.alpha));
  assign beta     = 18'($signed(req_i.beta));
  assign sin      = 18'($signed(req_i.score));

  // load: mate scores pulled toward zero by ply distance
  always_comb begin
    hit          = (entry_i.key == req_i.key);
    null_refused = !req_i.allow_null && (entry_i.move == 16'd0);
    is_mate      = 1'b0;
    adj          = sval;
    if (sval > win) begin
      adj     = sval - ply_dist;
      is_mate = 1'b1;
    end else if (sval < -win) begin
      adj     = sval + ply_dist;
      is_mate = 1'b1;
    end
    depth_ok = (entry_i.depth >= req_i.depth) || is_mate;
    case (entry_i.bound)
      BOUND_LOWER: usable = (adj >= beta);
      BOUND_UPPER: usable = (adj <= alpha);
      default:     usable = 1'b1;
    endcase
    usable = usable && depth_ok && hit && !null_refused;
  end

  // save: mate scores pushed outward, saturated to 16 bits
  always_comb begin
    in_hi = (sin > win);
    in_lo = (sin < -win);
    if (in_hi) begin
      vsum = sin + ply_dist;
    end else if (in_lo) begin
      vsum = sin - ply_dist;
    end else begin
      vsum = sin;
    end
    if (vsum > 18'sd32767) begin
      vsat = 18'sd32767;
    end else if (vsum < -18'sd32768) begin
      vsat = -18'sd32768;
    end else begin
      vsat = vsum;
    end
  end

  // result and write-back selection
  always_comb begin
    res_o          = '0;
    wb_o.we        = 1'b0;
    wb_o.entry.key   = req_i.key;
    wb_o.entry.bound = req_i.bound;
    wb_o.entry.depth = req_i.depth;
    wb_o.entry.score = vsat[15:0];
    wb_o.entry.move  = req_i.move;
    case (req_i.operation)
      OP_LOAD: begin
        res_o.score  = usable ? adj[15:0] : 16'(-{1'b0, cfg_i.mate_score});
        res_o.move   = (hit && !null_refused) ? entry_i.move : 16'd0;
        res_o.usable = usable;
      end
      OP_SAVE: begin
        wb_o.we        = (entry_i.depth <= req_i.depth);
        res_o.accepted = wb_o.we;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/core/transposition_table_depth_preferred_unit.sv
// ----------------------------------------------------------------------------
// transposition_table_depth_preferred_unit: direct-mapped transposition table
// Load/save probe: the RAM is read on accept, the entry is evaluated and written
// back in the probe state, then the result strobe is registered; busy stays high
// in the probe state. Clear: one entry zeroed per cycle, then a cleared result.
// Reset: registers to defaults, then a zeroing sweep of every table entry with
// busy high. Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module transposition_table_depth_preferred_unit import ttdp_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDefault  // power of two
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [31:0] position_key_i,
  input  logic [7:0]  ply_distance_i,
  input  logic [7:0]  search_depth_i,
  input  logic [15:0] alpha_bound_i,
  input  logic [15:0] beta_bound_i,
  input  logic [1:0]  bound_kind_i,
  input  logic [15:0] score_in_i,
  input  logic [15:0] move_in_i,
  input  logic        allow_null_entry_i,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [14:0] cfg_wdata_i,
  // result
  output logic        result_valid_o,
  output logic [15:0] score_out_o,
  output logic [15:0] move_out_o,
  output logic        score_usable_o,
  output logic        save_accepted_o,
  output logic        clear_done_o
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);

  ttdp_state_e  state_q, state_d;
  ttdp_req_t    req_q;
  ttdp_cfg_t    cfg_q;
  ttdp_result_t res_q, res_d, eval_res;
  ttdp_wb_t     eval_wb;
  logic         valid_q, valid_d;
  logic [IdxW-1:0] sweep_q, sweep_d;
  logic         accept, sweep_last;
  logic         mem_we;
  logic [IdxW-1:0] mem_waddr;
  logic [EntryWidth-1:0] mem_wdata, mem_rdata;

  assign accept     = start && !busy;
  assign sweep_last = (sweep_q == {IdxW{1'b1}});

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mate_score <= MateScoreReset;
      cfg_q.win_thresh <= WinThreshReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_MATE_SCORE: cfg_q.mate_score <= cfg_wdata_i;
        CFG_WIN_THRESH: cfg_q.win_thresh <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // request latch
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.operation  <= operation_i;
      req_q.key        <= position_key_i;
      req_q.ply_dist   <= ply_distance_i;
      req_q.depth      <= search_depth_i;
      req_q.alpha      <= alpha_bound_i;
      req_q.beta       <= beta_bound_i;
      req_q.bound      <= bound_kind_i;
      req_q.score      <= score_in_i;
      req_q.move       <= move_in_i;
      req_q.allow_null <= allow_null_entry_i;
    end
  end

  // table storage
  ttdp_mem #(
    .Entries (TABLE_ENTRIES),
    .IdxW    (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (accept),
    .raddr_i (position_key_i[IdxW-1:0]),
    .rdata_o (mem_rdata)
  );

  // probe evaluation
  ttdp_eval u_eval (
    .req_i   (req_q),
    .entry_i (ttdp_entry_t'(mem_rdata)),
    .cfg_i   (cfg_q),
    .res_o   (eval_res),
    .wb_o    (eval_wb)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT:  if (sweep_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          state_d = (operation_i == OP_CLEAR) ? ST_CLEAR : ST_PROBE;
        end
      end
      ST_PROBE: state_d = ST_IDLE;
      ST_CLEAR: if (sweep_last) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: memory writes, sweep counter, result
  always_comb begin
    busy      = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = req_q.key[IdxW-1:0];
    mem_wdata = eval_wb.entry;
    sweep_d   = sweep_q;
    valid_d   = 1'b0;
    res_d     = res_q;
    case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = '0;
        sweep_d   = sweep_q + 1'b1;
      end
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_PROBE: begin
        mem_we  = eval_wb.we;
        valid_d = 1'b1;
        res_d   = eval_res;
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = '0;
        sweep_d   = sweep_q + 1'b1;
        if (sweep_last) begin
          valid_d       = 1'b1;
          res_d         = '0;
          res_d.cleared = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      sweep_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      valid_q <= valid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o  = valid_q;
  assign score_out_o     = res_q.score;
  assign move_out_o      = res_q.move;
  assign score_usable_o  = res_q.usable;
  assign save_accepted_o = res_q.accepted;
  assign clear_done_o    = res_q.cleared;

endmodule
